// ===== src/tspls_pkg.sv =====
// Shared types and constants of the two-set priority-level scheduler.
package tspls_pkg;

    localparam int ID_W          = 4;
    localparam int PRIO_W        = 3;
    localparam int LEVEL_OUT_W   = 2;
    localparam int DEF_MAX_TASKS = 16;
    localparam int DEF_LEVELS    = 4;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_SELECT   = 1'b1;
    localparam logic KIND_FRESH   = 1'b0;
    localparam logic KIND_PREEMPT = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] static_priority;
        logic              arrival_kind;
    } sched_req_t;

    typedef struct packed {
        logic                   task_found;
        logic [ID_W-1:0]        chosen_task;
        logic [LEVEL_OUT_W-1:0] level_used;
        logic                   to_expired;
        logic                   sets_swapped;
        logic                   overflow;
    } sched_rsp_t;

endpackage

// ===== src/tspls_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tspls_ram #(
    parameter int WIDTH = tspls_pkg::ID_W,
    parameter int DEPTH = tspls_pkg::DEF_MAX_TASKS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/two_set_priority_level_scheduler.sv =====
// Top level of the two-set (active / expired) priority-level task scheduler.
//
// Usage:
//   A command transfer is taken at a rising edge where start is high and busy
//   is low; req carries command, task_id, static_priority and arrival_kind.
//   Enqueue places the task id in one of LEVELS FIFOs of the active or the
//   expired set; select pops the head of the highest non-empty active level,
//   swapping the sets first when the active set is empty.
//   Each command gives exactly one result on rsp, marked by done for a single
//   cycle. The receiver cannot stall: the result is taken in that cycle.
// Timing:
//   The result strobe follows the exec state; busy is high during exec, so a
//   new command cannot be taken while one is in flight, but can be taken in
//   the very cycle the previous result is shown. This is set by the registered
//   read data of the slot and level memories: the cycle of acceptance issues
//   the reads, the next one modifies and writes back.
// Reset:
//   rst_n clears the FIFO heads and fill counts, selects set 0 as active and
//   idles the sequencer. Slot and level memories are not cleared; no sweep is
//   needed, fill counts decide which slots hold data.
module two_set_priority_level_scheduler #(
    parameter int MAX_TASKS = tspls_pkg::DEF_MAX_TASKS,
    parameter int LEVELS    = tspls_pkg::DEF_LEVELS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tspls_pkg::sched_req_t req,
    output logic                  busy,
    output logic                  done,
    output tspls_pkg::sched_rsp_t rsp
);

    import tspls_pkg::*;

    localparam int NQ         = 2 * LEVELS;
    localparam int TASK_W     = $clog2(MAX_TASKS);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int Q_W        = $clog2(NQ);
    localparam int FILL_W     = $clog2(MAX_TASKS + 1);
    localparam int POS_W      = TASK_W + 1;
    localparam int SLOT_DEPTH = NQ * MAX_TASKS;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam int MOD_W      = (TASK_W + 1 > ID_W) ? TASK_W + 1 : ID_W;
    localparam int LV_EXT_W   = (LVL_W > LEVEL_OUT_W) ? LVL_W : LEVEL_OUT_W;
    localparam int BASE_W     = (LVL_W > PRIO_W) ? LVL_W : PRIO_W;

    // Sequencer: idle waits for a command, exec does read-modify-write.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    sched_req_t        req_reg;
    logic              sel_found_reg;
    logic              sel_swap_reg;
    logic [LVL_W-1:0]  sel_lv_reg;
    logic [Q_W-1:0]    sel_q_reg;
    logic              active_reg, active_next;
    logic [TASK_W-1:0] head_reg [NQ];
    logic [TASK_W-1:0] head_next [NQ];
    logic [FILL_W-1:0] fill_reg [NQ];
    logic [FILL_W-1:0] fill_next [NQ];
    logic              done_reg, done_next;
    sched_rsp_t        rsp_reg, rsp_next;

    logic accept;

    // Memory ports
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    logic [ID_W-1:0]    slot_rdata;
    logic               lvl_we;
    logic [TASK_W-1:0]  lvl_waddr, lvl_raddr;
    logic [LVL_W-1:0]   lvl_wdata, lvl_rdata;

    // Accept-side search
    logic [LEVELS-1:0] ne_act, ne_oth;
    logic              found_act, found_oth;
    logic [LVL_W-1:0]  lv_act, lv_oth;
    logic              srch_set, srch_found;
    logic [LVL_W-1:0]  srch_lv;
    logic [Q_W-1:0]    srch_q;

    // Exec-side enqueue
    logic [BASE_W-1:0] prio_ext, base_w;
    logic [LVL_W-1:0]  base_lv, enq_lv;
    logic              enq_set, enq_exp, enq_full;
    logic [Q_W-1:0]    enq_q;
    logic [POS_W-1:0]  pos_sum;
    logic [TASK_W-1:0] enq_pos;
    logic [LV_EXT_W-1:0] lv_ext;

    // Queue number of a (set, level) pair.
    function automatic logic [Q_W-1:0] qidx(input logic s, input logic [LVL_W-1:0] l);
        return Q_W'(s) * Q_W'(LEVELS) + Q_W'(l);
    endfunction

    // Task id folded into the level store's depth; id is narrow, so a few
    // compare-and-subtract steps suffice.
    function automatic logic [TASK_W-1:0] slot_of(input logic [ID_W-1:0] id);
        logic [MOD_W-1:0] r;
        r = MOD_W'(id);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= MOD_W'(MAX_TASKS))
            begin
                r = r - MOD_W'(MAX_TASKS);
            end
        end
        return r[TASK_W-1:0];
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_EXEC);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // Highest non-empty level in each set, from the fill counts.
    always_comb
    begin
        found_act = 1'b0;
        found_oth = 1'b0;
        lv_act    = '0;
        lv_oth    = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            ne_act[l] = (fill_reg[qidx(active_reg, LVL_W'(l))] != '0);
            ne_oth[l] = (fill_reg[qidx(~active_reg, LVL_W'(l))] != '0);
            if (ne_act[l])
            begin
                found_act = 1'b1;
                lv_act    = LVL_W'(l);
            end
            if (ne_oth[l])
            begin
                found_oth = 1'b1;
                lv_oth    = LVL_W'(l);
            end
        end
        srch_set   = found_act ? active_reg : ~active_reg;
        srch_lv    = found_act ? lv_act : lv_oth;
        srch_found = found_act | found_oth;
        srch_q     = qidx(srch_set, srch_lv);
    end

    // Reads are issued in the accepting cycle; data is there during exec.
    assign slot_raddr = SLOT_AW'(srch_q) * SLOT_AW'(MAX_TASKS) + SLOT_AW'(head_reg[srch_q]);
    assign lvl_raddr  = slot_of(req.task_id);

    // Enqueue target: level and set from arrival kind and stored level.
    always_comb
    begin
        prio_ext = BASE_W'(req_reg.static_priority);
        base_w   = (prio_ext == '0) ? '0 : prio_ext - BASE_W'(1);
        if (base_w > BASE_W'(LEVELS - 1))
        begin
            base_w = BASE_W'(LEVELS - 1);
        end
        base_lv = base_w[LVL_W-1:0];

        priority if (req_reg.arrival_kind == KIND_FRESH)
        begin
            enq_lv  = base_lv;
            enq_set = active_reg;
            enq_exp = 1'b0;
        end
        else if (lvl_rdata == '0)
        begin
            // quantum used up at the bottom level: expire with fresh level
            enq_lv  = base_lv;
            enq_set = ~active_reg;
            enq_exp = 1'b1;
        end
        else
        begin
            enq_lv  = lvl_rdata - LVL_W'(1);
            enq_set = active_reg;
            enq_exp = 1'b0;
        end

        enq_q    = qidx(enq_set, enq_lv);
        enq_full = (fill_reg[enq_q] == FILL_W'(MAX_TASKS));
        pos_sum  = POS_W'(head_reg[enq_q]) + POS_W'(fill_reg[enq_q]);
        if (pos_sum >= POS_W'(MAX_TASKS))
        begin
            pos_sum = pos_sum - POS_W'(MAX_TASKS);
        end
        enq_pos = pos_sum[TASK_W-1:0];
    end

    assign slot_waddr = SLOT_AW'(enq_q) * SLOT_AW'(MAX_TASKS) + SLOT_AW'(enq_pos);
    assign lvl_waddr  = slot_of(req_reg.task_id);
    assign lvl_wdata  = enq_lv;

    // Read-modify-write of the queue pointers and result formation.
    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        slot_we     = 1'b0;
        lvl_we      = 1'b0;
        lv_ext      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (req_reg.command == CMD_ENQUEUE)
                begin
                    lvl_we = 1'b1;
                    if (!enq_full)
                    begin
                        slot_we          = 1'b1;
                        fill_next[enq_q] = fill_reg[enq_q] + FILL_W'(1);
                    end
                    lv_ext                = LV_EXT_W'(enq_lv);
                    rsp_next.task_found   = 1'b0;
                    rsp_next.chosen_task  = req_reg.task_id;
                    rsp_next.level_used   = lv_ext[LEVEL_OUT_W-1:0];
                    rsp_next.to_expired   = enq_exp;
                    rsp_next.sets_swapped = 1'b0;
                    rsp_next.overflow     = enq_full;
                end
                else
                begin
                    if (sel_swap_reg)
                    begin
                        active_next = ~active_reg;
                    end
                    if (sel_found_reg)
                    begin
                        if (head_reg[sel_q_reg] == TASK_W'(MAX_TASKS - 1))
                        begin
                            head_next[sel_q_reg] = '0;
                        end
                        else
                        begin
                            head_next[sel_q_reg] = head_reg[sel_q_reg] + TASK_W'(1);
                        end
                        fill_next[sel_q_reg] = fill_reg[sel_q_reg] - FILL_W'(1);
                        lv_ext               = LV_EXT_W'(sel_lv_reg);
                    end
                    rsp_next.task_found   = sel_found_reg;
                    rsp_next.chosen_task  = sel_found_reg ? slot_rdata : '0;
                    rsp_next.level_used   = lv_ext[LEVEL_OUT_W-1:0];
                    rsp_next.to_expired   = 1'b0;
                    rsp_next.sets_swapped = sel_swap_reg;
                    rsp_next.overflow     = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            for (int q = 0; q < NQ; q++)
            begin
                head_reg[q] <= '0;
                fill_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            done_reg   <= done_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
        end
    end

    // Command and search result captured on the accepting transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= req;
            sel_found_reg <= srch_found;
            sel_swap_reg  <= ~found_act;
            sel_lv_reg    <= srch_lv;
            sel_q_reg     <= srch_q;
        end
        rsp_reg <= rsp_next;
    end

    tspls_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (req_reg.task_id),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    tspls_ram #(
        .WIDTH (LVL_W),
        .DEPTH (MAX_TASKS)
    ) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

endmodule
